### rtl/core/htc_pkg.sv
// Package: shared types, constants and opcodes for the Huffman tree codec.
`default_nettype none
package htc_pkg;
	localparam int MAX_LEAVES_DEF  = 8;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int CFG_W           = 4;
	localparam int SYM_W           = 8;
	localparam int CODE_W          = 7;
	localparam int LEN_W           = 3;
	localparam logic [CFG_W-1:0] LEAF_COUNT_RST = 4'd6;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_DECODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BCLR,
		ST_BPICK_A,
		ST_BPICK_B,
		ST_BMERGE,
		ST_ESRCH,
		ST_EWALK,
		ST_DEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [1:0] mode;
	} scan_ctl_t;

	localparam logic [1:0] SCAN_MIN  = 2'd0;
	localparam logic [1:0] SCAN_SYM  = 2'd1;
endpackage
`default_nettype wire

### rtl/core/huffman_tree_codec_top.sv
// Top level: Huffman tree build, encode and decode with a one-node-per-cycle scan unit.
// Load: on the last leaf the tree build follows.
// Encode: symbol search over the leaves, then a walk from the leaf up to the root.
// Decode: one tree step per item. One item at a time; the scan unit sets the build and search time.
// Result sits in an output register; the next item is taken once it is transferred.
// Reset clears tree links, loaded count and ready flag; leaf_count resets to 6.
`default_nettype none
module huffman_tree_codec_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // op[1:0], symbol[9:2], weight[25:10], bit_req[26]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // code[6:0], code_length[9:7], out_symbol[17:10]
	output logic        m_tuser,   // kind
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [3:0]  cfg_data
);
	localparam int MAX_LEAVES  = htc_pkg::MAX_LEAVES_DEF;
	localparam int WEIGHT_BITS = htc_pkg::WEIGHT_BITS_DEF;
	localparam int NODES  = 2 * MAX_LEAVES - 1;
	localparam int NODE_W = $clog2(NODES + 1);
	localparam int LC_W   = $clog2(MAX_LEAVES + 1);
	localparam int LI_W   = $clog2(MAX_LEAVES);
	localparam int WB     = WEIGHT_BITS + $clog2(MAX_LEAVES) + 1;
	localparam logic [NODE_W-1:0] NONE = NODE_W'(NODES);

	logic [WB-1:0]     wt_q   [NODES];
	logic [NODE_W-1:0] par_q  [NODES];
	logic [NODE_W-1:0] lft_q  [NODES];
	logic [NODE_W-1:0] rgt_q  [NODES];
	logic [htc_pkg::SYM_W-1:0] sym_q [MAX_LEAVES];

	logic [htc_pkg::CFG_W-1:0] lc_q;
	logic [LC_W-1:0]   loaded_q, nb_q, eff;
	logic [NODE_W-1:0] cur_q, iter_q, a_q, c_q;
	logic              ready_q;
	logic [htc_pkg::SYM_W-1:0] isym_q;
	logic              ibit_q;
	logic [htc_pkg::CODE_W-1:0] code_q;
	logic [htc_pkg::LEN_W-1:0]  len_q;
	logic              res_q;

	htc_pkg::state_t st_q, st_d;
	htc_pkg::scan_ctl_t sctl;
	logic [NODE_W-1:0] s_idx, s_best, s_lim;
	logic s_done, s_found;
	logic [NODE_W-1:0] root;
	logic [NODE_W-1:0] nxt, par_c;
	logic              acc;
	htc_pkg::op_t      iop;

	wire [1:0]  f_op  = s_tdata[1:0];
	wire [7:0]  f_sym = s_tdata[9:2];
	wire [15:0] f_wt  = s_tdata[25:10];
	wire        f_bit = s_tdata[26];

	assign iop       = htc_pkg::op_t'(f_op);
	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == htc_pkg::ST_IDLE);
	assign acc       = s_tvalid && s_tready;

	always_comb begin
		if (lc_q < 4'd2) eff = LC_W'(2);
		else if (32'(lc_q) > MAX_LEAVES) eff = LC_W'(MAX_LEAVES);
		else eff = LC_W'(lc_q);
	end

	assign root  = NODE_W'(2 * 32'(nb_q) - 2);
	assign s_lim = (st_q == htc_pkg::ST_ESRCH) ? NODE_W'(nb_q) : iter_q;

	logic sidx_ok;
	logic [LI_W-1:0] sidx_l;
	assign sidx_ok = 32'(s_idx) < NODES;
	assign sidx_l  = s_idx[LI_W-1:0];

	htc_scan #(.NODE_W(NODE_W), .WB(WB)) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.limit  (s_lim),
		.skip   (a_q),
		.skip_en(st_q == htc_pkg::ST_BPICK_B),
		.elig   (sidx_ok && par_q[sidx_ok ? s_idx : '0] == NONE),
		.wt     (wt_q[sidx_ok ? s_idx : '0]),
		.match  (32'(s_idx) < MAX_LEAVES && sym_q[sidx_l] == isym_q),
		.idx    (s_idx),
		.done   (s_done),
		.found  (s_found),
		.best   (s_best)
	);

	assign par_c = par_q[c_q];
	assign nxt   = ibit_q ? rgt_q[cur_q] : lft_q[cur_q];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			htc_pkg::ST_IDLE:
				if (acc) begin
					unique case (iop)
						htc_pkg::OP_LOAD:
							if ((ready_q ? LC_W'(1) : LC_W'(loaded_q + 1'b1)) >= eff)
								st_d = htc_pkg::ST_BCLR;
						htc_pkg::OP_ENCODE: if (ready_q) st_d = htc_pkg::ST_ESRCH;
						htc_pkg::OP_DECODE: if (ready_q) st_d = htc_pkg::ST_DEC;
						default: st_d = htc_pkg::ST_IDLE;
					endcase
				end
			htc_pkg::ST_BCLR:
				st_d = (iter_q >= NODE_W'(2 * 32'(nb_q) - 1)) ? htc_pkg::ST_IDLE
				                                              : htc_pkg::ST_BPICK_A;
			htc_pkg::ST_BPICK_A: if (s_done) st_d = htc_pkg::ST_BPICK_B;
			htc_pkg::ST_BPICK_B: if (s_done) st_d = htc_pkg::ST_BMERGE;
			htc_pkg::ST_BMERGE:
				st_d = (iter_q + 1'b1 >= NODE_W'(2 * 32'(nb_q) - 1)) ? htc_pkg::ST_IDLE
				                                                    : htc_pkg::ST_BPICK_A;
			htc_pkg::ST_ESRCH:
				if (s_done) st_d = s_found ? htc_pkg::ST_EWALK : htc_pkg::ST_IDLE;
			htc_pkg::ST_EWALK: if (par_c == NONE) st_d = htc_pkg::ST_OUT;
			htc_pkg::ST_DEC:
				st_d = (nxt != NONE && lft_q[nxt] == NONE) ? htc_pkg::ST_OUT
				                                           : htc_pkg::ST_IDLE;
			htc_pkg::ST_OUT: if (m_tready) st_d = htc_pkg::ST_IDLE;
			default: st_d = htc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sctl.start = 1'b0;
		sctl.mode  = htc_pkg::SCAN_MIN;
		if (st_q == htc_pkg::ST_BCLR && st_d == htc_pkg::ST_BPICK_A) sctl.start = 1'b1;
		if (st_q == htc_pkg::ST_BPICK_A && s_done) sctl.start = 1'b1;
		if (st_q == htc_pkg::ST_BMERGE && st_d == htc_pkg::ST_BPICK_A) sctl.start = 1'b1;
		if (st_q == htc_pkg::ST_IDLE && st_d == htc_pkg::ST_ESRCH) begin
			sctl.start = 1'b1;
			sctl.mode  = htc_pkg::SCAN_SYM;
		end
	end

	always_comb begin
		m_tvalid = (st_q == htc_pkg::ST_OUT);
		m_tuser  = res_q;
		m_tdata  = {6'd0, isym_q, len_q, code_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= htc_pkg::ST_IDLE;
			lc_q     <= htc_pkg::LEAF_COUNT_RST;
			loaded_q <= '0;
			ready_q  <= 1'b0;
			nb_q     <= LC_W'(6 < MAX_LEAVES ? 6 : MAX_LEAVES);
			cur_q    <= NODE_W'(2 * (6 < MAX_LEAVES ? 6 : MAX_LEAVES) - 2);
			iter_q   <= '0;
			for (int i = 0; i < NODES; i++) begin
				par_q[i] <= NONE;
				lft_q[i] <= NONE;
				rgt_q[i] <= NONE;
			end
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) lc_q <= cfg_data;
			unique case (st_q)
				htc_pkg::ST_IDLE:
					if (acc && iop == htc_pkg::OP_LOAD) begin
						ready_q <= 1'b0;
						if (ready_q) loaded_q <= LC_W'(1);
						else if (32'(loaded_q) < MAX_LEAVES) loaded_q <= loaded_q + 1'b1;
						if (st_d == htc_pkg::ST_BCLR) begin
							nb_q   <= eff;
							iter_q <= '0;
						end
					end
				htc_pkg::ST_BCLR: begin
					for (int i = 0; i < NODES; i++) begin
						par_q[i] <= NONE;
						lft_q[i] <= NONE;
						rgt_q[i] <= NONE;
					end
					iter_q  <= NODE_W'(nb_q);
					ready_q <= 1'b1;
					cur_q   <= root;
					if (iter_q >= NODE_W'(2 * 32'(nb_q) - 1)) iter_q <= iter_q;
				end
				htc_pkg::ST_BMERGE: begin
					par_q[a_q]      <= iter_q;
					par_q[s_best]   <= iter_q;
					lft_q[iter_q]   <= a_q;
					rgt_q[iter_q]   <= s_best;
					iter_q          <= iter_q + 1'b1;
				end
				htc_pkg::ST_DEC:
					if (nxt != NONE && lft_q[nxt] != NONE) cur_q <= nxt;
					else cur_q <= root;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (st_q)
			htc_pkg::ST_IDLE:
				if (acc) begin
					isym_q <= f_sym;
					ibit_q <= f_bit;
					if (iop == htc_pkg::OP_LOAD) begin
						if (ready_q) begin
							sym_q[0] <= f_sym;
							wt_q[0]  <= WB'(f_wt);
						end else if (32'(loaded_q) < MAX_LEAVES) begin
							sym_q[loaded_q[LI_W-1:0]]              <= f_sym;
							wt_q[NODE_W'(loaded_q)]                <= WB'(f_wt);
						end
					end
				end
			htc_pkg::ST_BPICK_A: if (s_done) a_q <= s_best;
			htc_pkg::ST_BMERGE: wt_q[iter_q] <= wt_q[a_q] + wt_q[s_best];
			htc_pkg::ST_ESRCH: begin
				c_q    <= s_best;
				code_q <= '0;
				len_q  <= '0;
			end
			htc_pkg::ST_EWALK:
				if (par_c != NONE) begin
					if (lft_q[par_c] != c_q)
						code_q[len_q] <= 1'b1;
					len_q <= len_q + 1'b1;
					c_q   <= par_c;
				end
			htc_pkg::ST_DEC: begin
				res_q  <= 1'b1;
				code_q <= '0;
				len_q  <= '0;
				if (32'(nxt) < MAX_LEAVES) isym_q <= sym_q[nxt[LI_W-1:0]];
				else isym_q <= '0;
			end
			default: ;
		endcase
		if (st_q == htc_pkg::ST_ESRCH) res_q <= 1'b0;
	end
endmodule
`default_nettype wire

### rtl/core/htc_scan.sv
// Shared scan unit: steps one node per cycle for least-weight search or symbol match.
`default_nettype none
module htc_scan #(
	parameter int NODE_W = 5,
	parameter int WB     = 19
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire htc_pkg::scan_ctl_t   ctl,
	input  wire [NODE_W-1:0]          limit,
	input  wire [NODE_W-1:0]          skip,
	input  wire                       skip_en,
	input  wire                       elig,
	input  wire [WB-1:0]              wt,
	input  wire                       match,
	output logic [NODE_W-1:0]         idx,
	output logic                      done,
	output logic                      found,
	output logic [NODE_W-1:0]         best
);
	logic              busy_q;
	logic [NODE_W-1:0] idx_q;
	logic [NODE_W-1:0] best_q;
	logic [WB-1:0]     bw_q;
	logic              fnd_q;
	logic [1:0]        mode_q;
	logic              take;

	assign idx   = idx_q;
	assign best  = best_q;
	assign found = fnd_q;
	assign done  = busy_q && (idx_q == limit);

	always_comb begin
		take = 1'b0;
		if (mode_q == htc_pkg::SCAN_MIN)
			take = elig && !(skip_en && idx_q == skip) && (!fnd_q || wt < bw_q);
		else
			take = match && !fnd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			fnd_q  <= 1'b0;
			mode_q <= htc_pkg::SCAN_MIN;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			fnd_q  <= 1'b0;
			mode_q <= ctl.mode;
		end else if (busy_q) begin
			if (idx_q == limit) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (take) fnd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && idx_q != limit && take) begin
			best_q <= idx_q;
			bw_q   <= wt;
		end
	end
endmodule
`default_nettype wire
